>>> rtl/sorted_array_insert_with_drop_macros.svh
// Assertion macros shared by the sorted array insert block.
`ifndef SORTED_ARRAY_INSERT_WITH_DROP_MACROS_SVH
`define SORTED_ARRAY_INSERT_WITH_DROP_MACROS_SVH

// Check a property on every rising edge outside reset.
`define SAI_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define SAI_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/sai_pkg.sv
// Types and request codes for the sorted array insert block.
package sai_pkg;

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_READ   = 2'd1;
    localparam logic [1:0] REQ_CLEAR  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRIME,
        ST_WALK,
        ST_TAIL,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic in_valid;
        logic start_walk;
        logic is_read;
        logic walk_last;
        logic walk_stop;
        logic out_free;
    } seq_stat_t;

    typedef struct packed {
        logic accept;
        logic prime;
        logic walk;
        logic tail;
        logic finish;
    } seq_ctrl_t;

endpackage

>>> rtl/sorted_array_insert_with_drop.sv
// Top level of the sorted array insert block: request capture, walk datapath and result beat.
// Keeps up to DEPTH signed 32-bit values in ascending order in a single-port-write RAM and
// answers one request at a time with one result beat. An insert walks the stored entries one
// per cycle through a single signed comparator, moving entries as it goes, through the prime,
// walk and tail states (the shift-left walk can stop early and then skips the tail); an insert
// into an empty array, a clear or an unknown request goes straight to the response, and a read
// passes through the prime state only, set by the one RAM read port. The next request is taken
// once the result has been loaded into the output register, even while that beat is still stalled.
`include "sorted_array_insert_with_drop_macros.svh"

module sorted_array_insert_with_drop #(
    parameter int DEPTH = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         req_type,
    input  logic signed [31:0] new_value,
    input  logic               shift_left,
    input  logic [3:0]         read_index,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               status,
    output logic signed [31:0] read_value,
    output logic               dropped_valid,
    output logic signed [31:0] dropped_value,
    output logic [4:0]         fill_level
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    sai_pkg::seq_stat_t stat;
    sai_pkg::seq_ctrl_t ctrl;

    logic [1:0]         req_reg,      req_next;
    logic signed [31:0] nv_reg,       nv_next;
    logic               left_reg,     left_next;
    logic [3:0]         idx_reg,      idx_next;
    logic               in_range_reg, in_range_next;
    logic [CW-1:0]      count_reg,    count_next;
    logic [CW-1:0]      ptr_reg,      ptr_next;
    logic [31:0]        carry_reg,    carry_next;
    logic               found_reg,    found_next;
    logic               dv_acc_reg,   dv_acc_next;
    logic [31:0]        dval_acc_reg, dval_acc_next;

    logic               out_valid_reg;
    logic               status_reg;
    logic signed [31:0] read_value_reg;
    logic               dv_reg;
    logic signed [31:0] dval_reg;
    logic [4:0]         fill_reg;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [31:0]   ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [31:0]   ram_rdata;

    logic [CW-1:0]   ptr_inc;
    logic [CW-1:0]   ptr_dec;
    logic [CW-1:0]   count_last;
    logic            walk_last;
    logic            entry_less;
    logic            walk_stop;
    logic [AW+3:0]   idx_wide;
    logic [CW+3:0]   in_idx_ext;
    logic [CW+3:0]   in_cnt_ext;
    logic [CW+4:0]   cnt_ext;
    logic            is_read_reg;

    assign ptr_inc    = ptr_reg + CW'(1);
    assign ptr_dec    = ptr_reg - CW'(1);
    assign count_last = count_reg - CW'(1);
    assign walk_last  = (ptr_reg == count_last);
    assign entry_less = ($signed(ram_rdata) < nv_reg);
    assign walk_stop  = left_reg && !entry_less;
    assign idx_wide   = {{AW{1'b0}}, idx_reg};
    assign in_idx_ext = {{CW{1'b0}}, read_index};
    assign in_cnt_ext = {4'd0, count_reg};
    assign cnt_ext    = {5'd0, count_reg};
    assign is_read_reg = (req_reg == sai_pkg::REQ_READ);

    always_comb
    begin
        stat.in_valid   = in_valid;
        stat.start_walk = (req_type == sai_pkg::REQ_READ)
                       || ((req_type == sai_pkg::REQ_INSERT) && (count_reg != '0));
        stat.is_read    = is_read_reg;
        stat.walk_last  = walk_last;
        stat.walk_stop  = walk_stop;
        stat.out_free   = !out_valid_reg || !out_stall;
    end

    sai_fsm u_fsm (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctrl  (ctrl)
    );

    sai_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        req_next      = req_reg;
        nv_next       = nv_reg;
        left_next     = left_reg;
        idx_next      = idx_reg;
        in_range_next = in_range_reg;
        count_next    = count_reg;
        ptr_next      = ptr_reg;
        carry_next    = carry_reg;
        found_next    = found_reg;
        dv_acc_next   = dv_acc_reg;
        dval_acc_next = dval_acc_reg;
        ram_we        = 1'b0;
        ram_waddr     = '0;
        ram_wdata     = '0;
        ram_re        = 1'b0;
        ram_raddr     = '0;

        if (ctrl.accept && in_valid)
        begin
            req_next      = req_type;
            nv_next       = new_value;
            left_next     = shift_left;
            idx_next      = read_index;
            in_range_next = (in_idx_ext < in_cnt_ext);
            ptr_next      = '0;
            carry_next    = new_value;
            found_next    = 1'b0;
            dv_acc_next   = 1'b0;
            dval_acc_next = '0;
            case (req_type)
                sai_pkg::REQ_INSERT:
                begin
                    if (count_reg == '0)
                    begin
                        ram_we     = 1'b1;
                        ram_wdata  = new_value;
                        count_next = CW'(1);
                    end
                end
                sai_pkg::REQ_CLEAR:
                begin
                    count_next = '0;
                end
                default:
                begin
                end
            endcase
        end

        if (ctrl.prime)
        begin
            ram_re    = 1'b1;
            ram_raddr = is_read_reg ? idx_wide[AW-1:0] : '0;
        end

        if (ctrl.walk)
        begin
            // fetch the next entry while this one is compared
            ram_re    = 1'b1;
            ram_raddr = ptr_inc[AW-1:0];
            if (!walk_last && !walk_stop)
            begin
                ptr_next = ptr_inc;
            end
            if (left_reg)
            begin
                if (entry_less)
                begin
                    if (ptr_reg == '0)
                    begin
                        dv_acc_next   = 1'b1;
                        dval_acc_next = ram_rdata;
                    end
                    else
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = ptr_dec[AW-1:0];
                        ram_wdata = ram_rdata;
                    end
                end
                else if (ptr_reg == '0)
                begin
                    dv_acc_next   = 1'b1;
                    dval_acc_next = nv_reg;
                end
                else
                begin
                    ram_we    = 1'b1;
                    ram_waddr = ptr_dec[AW-1:0];
                    ram_wdata = nv_reg;
                end
            end
            else if (found_reg || !entry_less)
            begin
                // ripple the held value up one place
                ram_we     = 1'b1;
                ram_waddr  = ptr_reg[AW-1:0];
                ram_wdata  = carry_reg;
                carry_next = ram_rdata;
                found_next = 1'b1;
            end
        end

        if (ctrl.tail)
        begin
            if (left_reg)
            begin
                ram_we    = 1'b1;
                ram_waddr = ptr_reg[AW-1:0];
                ram_wdata = nv_reg;
            end
            else if (count_reg < CW'(DEPTH))
            begin
                ram_we     = 1'b1;
                ram_waddr  = count_reg[AW-1:0];
                ram_wdata  = carry_reg;
                count_next = count_reg + CW'(1);
            end
            else
            begin
                // full: drop the largest
                dv_acc_next   = 1'b1;
                dval_acc_next = carry_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        nv_reg       <= nv_next;
        left_reg     <= left_next;
        idx_reg      <= idx_next;
        in_range_reg <= in_range_next;
        ptr_reg      <= ptr_next;
        carry_reg    <= carry_next;
        found_reg    <= found_next;
        dv_acc_reg   <= dv_acc_next;
        dval_acc_reg <= dval_acc_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.finish)
        begin
            status_reg     <= is_read_reg && !in_range_reg;
            read_value_reg <= (is_read_reg && in_range_reg) ? ram_rdata : '0;
            dv_reg         <= dv_acc_reg;
            dval_reg       <= dv_acc_reg ? dval_acc_reg : '0;
            fill_reg       <= cnt_ext[4:0];
        end
    end

    assign in_stall      = !ctrl.accept;
    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign read_value    = read_value_reg;
    assign dropped_valid = dv_reg;
    assign dropped_value = dval_reg;
    assign fill_level    = fill_reg;

    `SAI_ASSERT(a_count_bound, clk, rst_n, (count_reg <= CW'(DEPTH)), "fill count above depth")
    `SAI_ASSERT(a_count_step, clk, rst_n, (count_reg != $past(count_reg)) |-> ((count_reg == ($past(count_reg) + CW'(1))) || (count_reg == '0)), "fill count moved by more than one")
    `SAI_ASSERT(a_bad_read_zero, clk, rst_n, (out_valid_reg && status_reg) |-> ((read_value_reg == '0) && !dv_reg), "out-of-range read beat carries data")

endmodule

>>> rtl/sai_ram.sv
// Generic single write port, single read port RAM with registered read.
module sai_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/sai_fsm.sv
// Sequencer that steps one request through those of the prime, walk, tail and response states it needs.
module sai_fsm (
    input  logic               clk,
    input  logic               rst_n,
    input  sai_pkg::seq_stat_t stat,
    output sai_pkg::seq_ctrl_t ctrl
);

    sai_pkg::state_t state_reg;
    sai_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sai_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sai_pkg::ST_IDLE:
            begin
                if (stat.in_valid)
                begin
                    state_next = stat.start_walk ? sai_pkg::ST_PRIME : sai_pkg::ST_RESP;
                end
            end
            sai_pkg::ST_PRIME:
            begin
                state_next = stat.is_read ? sai_pkg::ST_RESP : sai_pkg::ST_WALK;
            end
            sai_pkg::ST_WALK:
            begin
                if (stat.walk_stop)
                begin
                    state_next = sai_pkg::ST_RESP;
                end
                else if (stat.walk_last)
                begin
                    state_next = sai_pkg::ST_TAIL;
                end
            end
            sai_pkg::ST_TAIL:
            begin
                state_next = sai_pkg::ST_RESP;
            end
            sai_pkg::ST_RESP:
            begin
                if (stat.out_free)
                begin
                    state_next = sai_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sai_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctrl = '0;
        case (state_reg)
            sai_pkg::ST_IDLE:  ctrl.accept = 1'b1;
            sai_pkg::ST_PRIME: ctrl.prime  = 1'b1;
            sai_pkg::ST_WALK:  ctrl.walk   = 1'b1;
            sai_pkg::ST_TAIL:  ctrl.tail   = 1'b1;
            sai_pkg::ST_RESP:  ctrl.finish = stat.out_free;
            default:           ctrl = '0;
        endcase
    end

endmodule
